>>> rtl/otirm_pkg.sv
// Package for the orbit-to-inertial rotation matrix block.
// Holds the transaction structs, the CORDIC arctangent table and fixed-point constants.
// No dependencies.
package otirm_pkg;

   localparam int AngleWidth = 24;
   localparam int ResWidth = 24;
   localparam int QWidth = 34;
   localparam int ZWidth = 34;
   localparam int AtanEntries = 30;
   localparam int DefaultStages = 22;
   localparam int WideWidth = 68;
   localparam logic signed [QWidth-1:0] CordicX0 = 34'sd652032874;
   localparam logic signed [QWidth+1:0] Q22One = 36'sd4194304;

   typedef struct packed {
      logic [AngleWidth-1:0] inclination;
      logic [AngleWidth-1:0] node_longitude;
      logic [AngleWidth-1:0] perigee_argument;
      logic [AngleWidth-1:0] true_anomaly;
   } req_type;

   typedef struct packed {
      logic signed [ResWidth-1:0] m00;
      logic signed [ResWidth-1:0] m01;
      logic signed [ResWidth-1:0] m02;
      logic signed [ResWidth-1:0] m10;
      logic signed [ResWidth-1:0] m11;
      logic signed [ResWidth-1:0] m12;
      logic signed [ResWidth-1:0] m20;
      logic signed [ResWidth-1:0] m21;
      logic signed [ResWidth-1:0] m22;
   } rsp_type;

   // Arctangent of 2^-k in units of 2^-32 turn, rounded to nearest.
   function automatic logic signed [ZWidth-1:0] atan_lookup(input logic [4:0] k);
      logic signed [ZWidth-1:0] r;
      case (k)
         5'd0: r = 34'sd536870912;
         5'd1: r = 34'sd316933406;
         5'd2: r = 34'sd167458907;
         5'd3: r = 34'sd85004756;
         5'd4: r = 34'sd42667331;
         5'd5: r = 34'sd21354465;
         5'd6: r = 34'sd10679838;
         5'd7: r = 34'sd5340245;
         5'd8: r = 34'sd2670163;
         5'd9: r = 34'sd1335087;
         5'd10: r = 34'sd667544;
         5'd11: r = 34'sd333772;
         5'd12: r = 34'sd166886;
         5'd13: r = 34'sd83443;
         5'd14: r = 34'sd41722;
         5'd15: r = 34'sd20861;
         5'd16: r = 34'sd10430;
         5'd17: r = 34'sd5215;
         5'd18: r = 34'sd2608;
         5'd19: r = 34'sd1304;
         5'd20: r = 34'sd652;
         5'd21: r = 34'sd326;
         5'd22: r = 34'sd163;
         5'd23: r = 34'sd81;
         5'd24: r = 34'sd41;
         5'd25: r = 34'sd20;
         5'd26: r = 34'sd10;
         5'd27: r = 34'sd5;
         5'd28: r = 34'sd3;
         5'd29: r = 34'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Product of two Q30 values, rounded half up with a floor shift.
   function automatic logic signed [QWidth-1:0] qmul(
      input logic signed [QWidth-1:0] a,
      input logic signed [QWidth-1:0] b
   );
      logic signed [WideWidth-1:0] p;
      p = WideWidth'(a) * WideWidth'(b) + (WideWidth'(1) <<< 29);
      return QWidth'(p >>> 30);
   endfunction

   // Q30 sum to Q2.22, rounded and clamped to plus or minus one.
   function automatic logic [ResWidth-1:0] to_q22(input logic signed [QWidth+1:0] v);
      logic signed [QWidth+1:0] r;
      r = (v + 36'sd128) >>> 8;
      if (r > Q22One) r = Q22One;
      if (r < -Q22One) r = -Q22One;
      return r[ResWidth-1:0];
   endfunction

endpackage

>>> rtl/orbit_to_inertial_rotation_matrix.sv
// Top level of the orbit-to-inertial rotation matrix block.
// Depends on otirm_pkg for transaction types, the arctangent table and rounding helpers.
// One angle set enters per cycle while the pipeline advances; the stages are one input stage,
// one CORDIC stage per iteration, a quadrant stage, two multiplier stages and an output
// register. The shared pipeline advances whenever the output register is free or being
// taken, so a stalled result holds every stage without loss.
module orbit_to_inertial_rotation_matrix
   import otirm_pkg::*;
#(
   parameter int CORDIC_STAGES = DefaultStages
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int NStage = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
   localparam int Depth = NStage + 5;

   typedef logic signed [QWidth-1:0] q_type;
   typedef logic [1:0] quad_type;

   // Pipeline advances when the output register is free or being emptied.
   logic advance;
   logic [Depth-1:0] valid_ff;
   logic [Depth-1:0] valid_in;
   assign advance = !valid_ff[Depth-1] || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      valid_in = {valid_ff[Depth-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // CORDIC state for the three angles: index 0 inclination, 1 node, 2 latitude.
   q_type    x_ff [0:NStage][0:2];
   q_type    y_ff [0:NStage][0:2];
   q_type    z_ff [0:NStage][0:2];
   quad_type quad_ff [0:NStage][0:2];

   // Input stage: argument of latitude and the initial CORDIC vector.
   logic [AngleWidth-1:0] ang_in [0:2];
   always_comb begin
      ang_in[0] = req_data.inclination;
      ang_in[1] = req_data.node_longitude;
      ang_in[2] = req_data.perigee_argument + req_data.true_anomaly;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < 3; a++) begin
            x_ff[0][a] <= CordicX0;
            y_ff[0][a] <= '0;
            z_ff[0][a] <= {4'b0, ang_in[a][AngleWidth-3:0], 8'b0};
            quad_ff[0][a] <= ang_in[a][AngleWidth-1:AngleWidth-2];
         end
      end
   end

   // One CORDIC micro-rotation per stage.
   for (genvar k = 0; k < NStage; k++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (advance) begin
            for (int a = 0; a < 3; a++) begin
               if (!z_ff[k][a][ZWidth-1]) begin
                  x_ff[k+1][a] <= x_ff[k][a] - (y_ff[k][a] >>> k);
                  y_ff[k+1][a] <= y_ff[k][a] + (x_ff[k][a] >>> k);
                  z_ff[k+1][a] <= z_ff[k][a] - atan_lookup(5'(k));
               end else begin
                  x_ff[k+1][a] <= x_ff[k][a] + (y_ff[k][a] >>> k);
                  y_ff[k+1][a] <= y_ff[k][a] - (x_ff[k][a] >>> k);
                  z_ff[k+1][a] <= z_ff[k][a] + atan_lookup(5'(k));
               end
               quad_ff[k+1][a] <= quad_ff[k][a];
            end
         end
      end
   end

   // Quadrant fold into cosine and sine.
   q_type c_ff [0:2];
   q_type s_ff [0:2];
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < 3; a++) begin
            case (quad_ff[NStage][a])
               2'd0: begin
                  c_ff[a] <= x_ff[NStage][a];  s_ff[a] <= y_ff[NStage][a];
               end
               2'd1: begin
                  c_ff[a] <= -y_ff[NStage][a]; s_ff[a] <= x_ff[NStage][a];
               end
               2'd2: begin
                  c_ff[a] <= -x_ff[NStage][a]; s_ff[a] <= -y_ff[NStage][a];
               end
               default: begin
                  c_ff[a] <= y_ff[NStage][a];  s_ff[a] <= -x_ff[NStage][a];
               end
            endcase
         end
      end
   end

   // First multiplier stage: the eight pair products; ci carried along.
   q_type cucw_ff, susw_ff, cusw_ff, sucw_ff, sisw_ff, sicw_ff, susi_ff, cusi_ff, ci_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         cucw_ff <= qmul(c_ff[2], c_ff[1]);
         susw_ff <= qmul(s_ff[2], s_ff[1]);
         cusw_ff <= qmul(c_ff[2], s_ff[1]);
         sucw_ff <= qmul(s_ff[2], c_ff[1]);
         sisw_ff <= qmul(s_ff[0], s_ff[1]);
         sicw_ff <= qmul(s_ff[0], c_ff[1]);
         susi_ff <= qmul(s_ff[2], s_ff[0]);
         cusi_ff <= qmul(c_ff[2], s_ff[0]);
         ci_ff   <= c_ff[0];
      end
   end

   // Second multiplier stage: triple products; pair products and ci carried along.
   q_type t0_ff, t1_ff, t3_ff, t4_ff;
   q_type cucw2_ff, sucw2_ff, cusw2_ff, susw2_ff, sisw2_ff, sicw2_ff, susi2_ff, cusi2_ff;
   q_type ci2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         t0_ff <= qmul(susw_ff, ci_ff);
         t1_ff <= qmul(cusw_ff, ci_ff);
         t3_ff <= qmul(sucw_ff, ci_ff);
         t4_ff <= qmul(cucw_ff, ci_ff);
         cucw2_ff <= cucw_ff; sucw2_ff <= sucw_ff;
         cusw2_ff <= cusw_ff; susw2_ff <= susw_ff;
         sisw2_ff <= sisw_ff; sicw2_ff <= sicw_ff;
         susi2_ff <= susi_ff; cusi2_ff <= cusi_ff;
         ci2_ff <= ci_ff;
      end
   end

   // Output register: sums, rounding and clamping.
   rsp_type rsp_in, rsp_ff;
   always_comb begin
      rsp_in.m00 = to_q22(36'(cucw2_ff) - 36'(t0_ff));
      rsp_in.m01 = to_q22(-36'(sucw2_ff) - 36'(t1_ff));
      rsp_in.m02 = to_q22(36'(sisw2_ff));
      rsp_in.m10 = to_q22(36'(cusw2_ff) + 36'(t3_ff));
      rsp_in.m11 = to_q22(-36'(susw2_ff) + 36'(t4_ff));
      rsp_in.m12 = to_q22(-36'(sicw2_ff));
      rsp_in.m20 = to_q22(36'(susi2_ff));
      rsp_in.m21 = to_q22(36'(cusi2_ff));
      rsp_in.m22 = to_q22(36'(ci2_ff));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff[Depth-1];
   assign rsp_data  = rsp_ff;

endmodule

>>> test/tb_top.sv
// Testbench for orbit_to_inertial_rotation_matrix: drives angle-set transactions and
// checks every rotation matrix against an in-bench CORDIC predictor.
// Depends on otirm_pkg for the transaction structs only.
`timescale 1ns / 1ps
module tb_top
   import otirm_pkg::*;
;

   localparam int NumStages = 22;
   localparam int NumRandom = 1200;
   localparam int Latency = NumStages + 5;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type matrix_queue[$];
   int      error_count = 0;
   bit      quiet_phase = 1'b0;
   bit      hold_off_request = 1'b0;

   orbit_to_inertial_rotation_matrix #(.CORDIC_STAGES(NumStages)) u_top (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Arctangent of 2^-k in 2^-32 turn.
   const longint arctan_turn[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722,
      20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

   function automatic longint round_q30(longint a, longint b);
      return (a * b + (longint'(1) << 29)) >>> 30;
   endfunction

   // Rotation-mode CORDIC with quadrant folding.
   function automatic void cordic_sincos(logic [23:0] angle, output longint c,
                                         output longint s);
      longint x, y, z, dx, dy;
      x = 652032874;
      y = 0;
      z = longint'(angle[21:0]) << 8;
      for (int k = 0; k < NumStages && k < 30; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_turn[k];
         end else begin
            x += dx; y -= dy; z += arctan_turn[k];
         end
      end
      case (angle[23:22])
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic logic [23:0] clamp_q22(longint v);
      longint r;
      r = (v + 128) >>> 8;
      if (r > 4194304) r = 4194304;
      if (r < -4194304) r = -4194304;
      return r[23:0];
   endfunction

   function automatic rsp_type predict_matrix(req_type a);
      longint ci, si, cw, sw, cu, su;
      logic [23:0] lat;
      rsp_type m;
      lat = a.perigee_argument + a.true_anomaly;
      cordic_sincos(a.inclination, ci, si);
      cordic_sincos(a.node_longitude, cw, sw);
      cordic_sincos(lat, cu, su);
      m.m00 = clamp_q22(round_q30(cu, cw) - round_q30(round_q30(su, sw), ci));
      m.m01 = clamp_q22(-round_q30(su, cw) - round_q30(round_q30(cu, sw), ci));
      m.m02 = clamp_q22(round_q30(si, sw));
      m.m10 = clamp_q22(round_q30(cu, sw) + round_q30(round_q30(su, cw), ci));
      m.m11 = clamp_q22(-round_q30(su, sw) + round_q30(round_q30(cu, cw), ci));
      m.m12 = clamp_q22(-round_q30(si, cw));
      m.m20 = clamp_q22(round_q30(su, si));
      m.m21 = clamp_q22(round_q30(cu, si));
      m.m22 = clamp_q22(ci);
      return m;
   endfunction

   // Send one transaction, with an optional random gap beforehand.
   // Acceptance is judged on the ready value seen at the edge itself.
   task automatic send_angles(req_type a);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= a;
      @(posedge clock iff req_ready);
   endtask

   function automatic logic [23:0] random_angle();
      case ($urandom_range(0, 5))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         2: return {2'($urandom_range(0, 3)), 22'h000000};
         3: return {2'($urandom_range(0, 3)), 22'h3FFFFF};
         default: return 24'($urandom);
      endcase
   endfunction

   // Expectation store fed at each accepted input transaction.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) matrix_queue.push_back(predict_matrix(req_data));
   end

   // Result checking at each accepted output transaction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (matrix_queue.size() == 0) begin
            $error("unexpected result transaction");
            error_count++;
         end else begin
            want = matrix_queue.pop_front();
            if (rsp_data.m00 !== want.m00) begin
               $error("m00 expected %0d got %0d", want.m00, rsp_data.m00); error_count++; end
            if (rsp_data.m01 !== want.m01) begin
               $error("m01 expected %0d got %0d", want.m01, rsp_data.m01); error_count++; end
            if (rsp_data.m02 !== want.m02) begin
               $error("m02 expected %0d got %0d", want.m02, rsp_data.m02); error_count++; end
            if (rsp_data.m10 !== want.m10) begin
               $error("m10 expected %0d got %0d", want.m10, rsp_data.m10); error_count++; end
            if (rsp_data.m11 !== want.m11) begin
               $error("m11 expected %0d got %0d", want.m11, rsp_data.m11); error_count++; end
            if (rsp_data.m12 !== want.m12) begin
               $error("m12 expected %0d got %0d", want.m12, rsp_data.m12); error_count++; end
            if (rsp_data.m20 !== want.m20) begin
               $error("m20 expected %0d got %0d", want.m20, rsp_data.m20); error_count++; end
            if (rsp_data.m21 !== want.m21) begin
               $error("m21 expected %0d got %0d", want.m21, rsp_data.m21); error_count++; end
            if (rsp_data.m22 !== want.m22) begin
               $error("m22 expected %0d got %0d", want.m22, rsp_data.m22); error_count++; end
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      @(negedge reset);
      forever begin
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (3 * Latency) @(posedge clock);
            hold_off_request = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Directed rows: angle set, and where obvious the expected matrix.
   typedef struct {
      req_type angles;
      bit      has_matrix;
      rsp_type matrix;
   } angle_row_type;

   angle_row_type directed_rows[$];

   initial begin
      req_type a;
      rsp_type ident;
      int waited;
      ident = '{m00: 24'sd4194304, m01: 24'sd0, m02: 24'sd0, m10: 24'sd0,
                m11: 24'sd4194304, m12: 24'sd0, m20: 24'sd0, m21: 24'sd0, m22: 24'sd4194304};
      // All-zero angles give the identity matrix.
      directed_rows.push_back('{'{24'h0, 24'h0, 24'h0, 24'h0}, 1'b1, ident});
      // Latitude sum wrapping round to zero also gives the identity.
      directed_rows.push_back('{'{24'h0, 24'h0, 24'hFFFFFF, 24'h000001}, 1'b1, ident});
      directed_rows.push_back('{'{24'h0, 24'h0, 24'h800000, 24'h800000}, 1'b1, ident});
      directed_rows.push_back('{'{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 0, '0});
      for (int q = 0; q < 4; q++) begin
         directed_rows.push_back('{'{{q[1:0], 22'h0}, 24'h0, 24'h0, 24'h0}, 0, '0});
         directed_rows.push_back('{'{24'h0, {q[1:0], 22'h0}, 24'h0, 24'h0}, 0, '0});
         directed_rows.push_back('{'{24'h0, 24'h0, {q[1:0], 22'h3FFFFF}, 24'h0}, 0, '0});
         directed_rows.push_back('{'{{q[1:0], 22'h3FFFFF}, {q[1:0], 22'h200000},
                                     24'h0, {q[1:0], 22'h0}}, 0, '0});
      end
      directed_rows.push_back('{'{24'h200000, 24'h600000, 24'hC00000, 24'h7FFFFF}, 0, '0});
      directed_rows.push_back('{'{24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA}, 0, '0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         a = directed_rows[i].angles;
         if (directed_rows[i].has_matrix && predict_matrix(a) != directed_rows[i].matrix) begin
            $error("row %0d: predictor disagrees with the typed matrix", i);
            error_count++;
         end
         send_angles(a);
      end

      for (int n = 0; n < NumRandom; n++) begin
         // Long receiver hold-off while transactions keep coming.
         if (n == 200) hold_off_request = 1'b1;
         // Sender pause until the pipeline has drained.
         if (n == 500) begin
            req_valid <= 1'b0;
            while (matrix_queue.size() != 0) @(posedge clock);
         end
         if (n == NumRandom - 150) quiet_phase = 1'b1;
         a.inclination = random_angle();
         a.node_longitude = random_angle();
         a.perigee_argument = random_angle();
         a.true_anomaly = random_angle();
         send_angles(a);
      end
      req_valid <= 1'b0;

      waited = 0;
      while (matrix_queue.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (2 * Latency) @(posedge clock);
      if (error_count == 0 && matrix_queue.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> sim.f
rtl/otirm_pkg.sv
rtl/orbit_to_inertial_rotation_matrix.sv
test/tb_top.sv
